### src/sgr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgr_pkg
// Shared types and constants of the scaled glyph renderer.
// ----------------------------------------------------------------------------
package sgr_pkg;

    // fixed glyph and screen geometry
    localparam int SGR_GLYPH_W    = 8;
    localparam int SGR_GLYPH_H    = 8;
    localparam int SGR_SCREEN_W   = 320;
    localparam int SGR_MAX_SCALE  = 4;
    localparam int SGR_ROW_LIMIT  = 32;

    // field widths
    localparam int SGR_OP_W       = 2;
    localparam int SGR_IDX_W      = 11;
    localparam int SGR_BITS_W     = 8;
    localparam int SGR_CODE_W     = 8;
    localparam int SGR_X_W        = 12;
    localparam int SGR_Y_W        = 8;
    localparam int SGR_ADDR_W     = 17;
    localparam int SGR_MASK_W     = 32;
    localparam int SGR_COLOR_W    = 8;
    localparam int SGR_SCALE_W    = 3;
    localparam int SGR_CFG_IDX_W  = 2;
    localparam int SGR_CFG_DATA_W = 8;
    localparam int SGR_ROW_W      = $clog2(SGR_ROW_LIMIT);
    localparam int SGR_STORE_DEPTH = 2 ** SGR_IDX_W;

    typedef enum logic [SGR_OP_W-1:0] {
        OP_LOAD     = 2'd0,
        OP_DRAW_POS = 2'd1,
        OP_DRAW_CUR = 2'd2,
        OP_NONE     = 2'd3
    } t_opcode;

    typedef enum logic [SGR_CFG_IDX_W-1:0] {
        REG_SCALE = 2'd0,
        REG_COLOR = 2'd1
    } t_reg_index;

    typedef enum logic {
        BK_IDLE,
        BK_DRAW
    } t_back_state;

    // one classified request between front and back
    typedef struct packed {
        logic                  is_load;
        logic [SGR_IDX_W-1:0]  index;
        logic [SGR_BITS_W-1:0] bits;
        logic [SGR_CODE_W-1:0] code;
        logic [SGR_X_W-1:0]    x;
        logic [SGR_Y_W-1:0]    y;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_push;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_pop;

endpackage

### src/sgr_ifaces.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgr interfaces
// Request, result and register write channels of the glyph renderer.
// ----------------------------------------------------------------------------
interface sgr_in_if;
    import sgr_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [SGR_OP_W-1:0]   opcode;
    logic [SGR_IDX_W-1:0]  font_index;
    logic [SGR_BITS_W-1:0] font_bits;
    logic [SGR_CODE_W-1:0] char_code;
    logic [SGR_X_W-1:0]    pos_x;
    logic [SGR_Y_W-1:0]    pos_y;

    modport source (output valid, opcode, font_index, font_bits, char_code,
                    pos_x, pos_y, input ready);
    modport sink   (input valid, opcode, font_index, font_bits, char_code,
                    pos_x, pos_y, output ready);
endinterface

interface sgr_out_if;
    import sgr_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [SGR_ADDR_W-1:0]  row_address;
    logic [SGR_MASK_W-1:0]  pixel_mask;
    logic [SGR_COLOR_W-1:0] pixel_color;
    logic                   last_row;

    modport source (output valid, row_address, pixel_mask, pixel_color, last_row,
                    input ready);
    modport sink   (input valid, row_address, pixel_mask, pixel_color, last_row,
                    output ready);
endinterface

interface sgr_cfg_if;
    import sgr_pkg::*;
    logic                      valid;
    logic                      ready;
    logic [SGR_CFG_IDX_W-1:0]  index;
    logic [SGR_CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### src/sgr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgr_front
// Accepts requests, drops unused opcodes, resolves the cursor for draws.
// ----------------------------------------------------------------------------
module sgr_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    sgr_in_if.sink                       i_in,
    input  logic [sgr_pkg::SGR_SCALE_W-1:0] i_scale,
    output sgr_pkg::t_push               o_push,
    input  logic                         i_push_ready
);
    import sgr_pkg::*;

    logic [SGR_X_W-1:0] r_cur_x, n_cur_x;
    logic [SGR_Y_W-1:0] r_cur_y, n_cur_y;
    t_opcode            op;
    logic               accept;
    logic [SGR_X_W-1:0] draw_x;
    logic [SGR_Y_W-1:0] draw_y;

    assign op          = t_opcode'(i_in.opcode);
    assign i_in.ready  = i_push_ready;
    assign accept      = i_in.valid && i_push_ready;

    always_comb begin
        draw_x = r_cur_x;
        draw_y = r_cur_y;
        if (op == OP_DRAW_POS) begin
            draw_x = i_in.pos_x;
            draw_y = i_in.pos_y;
        end
    end

    always_comb begin
        o_push.valid       = i_in.valid && (op != OP_NONE);
        o_push.cmd.is_load = (op == OP_LOAD);
        o_push.cmd.index   = i_in.font_index;
        o_push.cmd.bits    = i_in.font_bits;
        o_push.cmd.code    = i_in.char_code;
        o_push.cmd.x       = draw_x;
        o_push.cmd.y       = draw_y;
    end

    always_comb begin
        n_cur_x = r_cur_x;
        n_cur_y = r_cur_y;
        if (accept && (op == OP_DRAW_POS || op == OP_DRAW_CUR)) begin
            n_cur_x = draw_x + SGR_X_W'(i_scale) * SGR_X_W'(SGR_GLYPH_W);
            n_cur_y = draw_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x <= '0;
            r_cur_y <= '0;
        end else begin
            r_cur_x <= n_cur_x;
            r_cur_y <= n_cur_y;
        end
    end

endmodule

### src/sgr_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgr_queue
// Two-entry queue of classified requests between front and back.
// ----------------------------------------------------------------------------
module sgr_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  sgr_pkg::t_push i_push,
    output logic           o_push_ready,
    output sgr_pkg::t_pop  o_pop,
    input  logic           i_pop_ready
);
    import sgr_pkg::*;

    t_cmd       r_slot [2];
    logic       r_wr_ptr, r_rd_ptr;
    logic [1:0] r_count;
    logic       do_push, do_pop;

    assign o_push_ready = (r_count != 2'd2);
    assign do_push      = i_push.valid && o_push_ready;
    assign do_pop       = o_pop.valid && i_pop_ready;
    assign o_pop.valid  = (r_count != 2'd0);
    assign o_pop.cmd    = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_push.cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + 2'(do_push) - 2'(do_pop);
        end
    end

endmodule

### src/sgr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgr_back
// Holds the glyph store, writes loads and walks the scaled rows of draws.
// ----------------------------------------------------------------------------
module sgr_back (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  sgr_pkg::t_pop                    i_pop,
    output logic                             o_pop_ready,
    input  logic [sgr_pkg::SGR_SCALE_W-1:0]  i_scale,
    input  logic [sgr_pkg::SGR_COLOR_W-1:0]  i_color,
    sgr_out_if.source                        o_out
);
    import sgr_pkg::*;

    function automatic logic [SGR_MASK_W-1:0] row_mask(
        input logic [SGR_BITS_W-1:0]  bits,
        input logic [SGR_SCALE_W-1:0] s
    );
        logic [SGR_MASK_W-1:0] m;
        int                    b;
        m = '0;
        for (int c = 0; c < SGR_GLYPH_W; c++) begin
            for (int k = 0; k < SGR_MAX_SCALE; k++) begin
                b = c * int'(s) + k;
                if (bits[SGR_BITS_W-1-c] && k < int'(s) && b < SGR_MASK_W) begin
                    m[b[4:0]] = 1'b1;
                end
            end
        end
        return m;
    endfunction

    logic [SGR_BITS_W-1:0] r_store [SGR_STORE_DEPTH];

    t_back_state r_state, n_state;

    // row sequencer
    logic [SGR_ADDR_W-1:0]  r_addr;
    logic [SGR_IDX_W-1:0]   r_idx;
    logic [SGR_ROW_W-1:0]   r_row;
    logic [SGR_ROW_W-1:0]   r_last;
    logic [SGR_SCALE_W-1:0] r_sub;

    // stage 1: store read in flight
    logic                   r_s1_valid;
    logic [SGR_ADDR_W-1:0]  r_s1_addr;
    logic                   r_s1_last;
    logic [SGR_BITS_W-1:0]  r_rdata;

    // stage 2: output register
    logic                   r_o_valid;
    logic [SGR_ADDR_W-1:0]  r_o_addr;
    logic [SGR_MASK_W-1:0]  r_o_mask;
    logic [SGR_COLOR_W-1:0] r_o_color;
    logic                   r_o_last;

    logic                   s2_free, s1_free, issue, pop_take, row_end;
    logic [7:0]             total_rows;
    logic [SGR_ROW_W-1:0]   last_row_num;

    assign s2_free  = !r_o_valid || o_out.ready;
    assign s1_free  = !r_s1_valid || s2_free;
    assign pop_take = i_pop.valid && o_pop_ready;
    assign row_end  = (r_row == r_last);

    assign total_rows   = 8'(i_scale) * 8'(SGR_GLYPH_H);
    assign last_row_num = (total_rows >= 8'(SGR_ROW_LIMIT)) ? SGR_ROW_W'(SGR_ROW_LIMIT - 1)
                                                           : SGR_ROW_W'(total_rows - 8'd1);

    always_comb begin
        n_state     = r_state;
        o_pop_ready = 1'b0;
        issue       = 1'b0;
        case (r_state)
            BK_IDLE: begin
                o_pop_ready = 1'b1;
                if (i_pop.valid && !i_pop.cmd.is_load) begin
                    n_state = BK_DRAW;
                end
            end
            BK_DRAW: begin
                issue = s1_free;
                if (s1_free && row_end) begin
                    n_state = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // glyph store, registered read
    always_ff @(posedge i_clk) begin
        if (pop_take && i_pop.cmd.is_load) begin
            r_store[i_pop.cmd.index] <= i_pop.cmd.bits;
        end
        if (issue) begin
            r_rdata <= r_store[r_idx];
        end
    end

    // sequencer payload
    always_ff @(posedge i_clk) begin
        if (pop_take && !i_pop.cmd.is_load) begin
            r_addr <= SGR_ADDR_W'(i_pop.cmd.y) * SGR_ADDR_W'(SGR_SCREEN_W)
                    + SGR_ADDR_W'(i_pop.cmd.x);
            r_idx  <= SGR_IDX_W'(32'(i_pop.cmd.code) * SGR_GLYPH_H);
            r_row  <= '0;
            r_sub  <= '0;
            r_last <= last_row_num;
        end else if (issue) begin
            r_addr <= r_addr + SGR_ADDR_W'(SGR_SCREEN_W);
            r_row  <= r_row + 1'b1;
            // next glyph row once a row has been repeated scale times
            if (r_sub == i_scale - 1'b1) begin
                r_sub <= '0;
                r_idx <= r_idx + 1'b1;
            end else begin
                r_sub <= r_sub + 1'b1;
            end
        end
        if (issue) begin
            r_s1_addr <= r_addr;
            r_s1_last <= row_end;
        end
        if (r_s1_valid && s2_free) begin
            r_o_addr  <= r_s1_addr;
            r_o_mask  <= row_mask(r_rdata, i_scale);
            r_o_color <= i_color;
            r_o_last  <= r_s1_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (s1_free) begin
                r_s1_valid <= issue;
            end
            if (s2_free) begin
                r_o_valid <= r_s1_valid;
            end
        end
    end

    assign o_out.valid       = r_o_valid;
    assign o_out.row_address = r_o_addr;
    assign o_out.pixel_mask  = r_o_mask;
    assign o_out.pixel_color = r_o_color;
    assign o_out.last_row    = r_o_last;

`ifndef NO_ASSERTIONS
    // the final row issued always returns the sequencer to idle
    a_last_ends_draw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (issue && row_end) |=> (r_state == BK_IDLE))
        else $error("draw did not end after its last row");

    // no new request is taken while a glyph is being walked
    a_no_pop_in_draw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_DRAW) |-> !pop_take)
        else $error("request taken during a draw");

    // mask bits stay inside the scaled glyph width
    a_mask_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> ((r_o_mask >> (int'(i_scale) * SGR_GLYPH_W)) == '0))
        else $error("mask bit beyond scaled glyph width");

    // row counter never passes the programmed last row
    a_row_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_DRAW) |-> (r_row <= r_last))
        else $error("row counter overran");
`endif

endmodule

### src/scaled_glyph_renderer.sv
// ----------------------------------------------------------------------------
// scaled_glyph_renderer
// A draw passes the queue, the sequencer, the store read and the output register.
// Throughput: one row a cycle while output is ready; a draw gives 8 * scale rows
// (at most 32), then the back goes idle to take the next request, as it does loads.
// Reset (i_rst_n, synchronous): cursor 0/0, scale 1, color 1, queue empty;
// the glyph store is not cleared and needs loading before use.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module scaled_glyph_renderer (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sgr_in_if.sink    i_in,
    sgr_cfg_if.sink   i_cfg,
    sgr_out_if.source o_out
);
    import sgr_pkg::*;

    logic [SGR_SCALE_W-1:0] r_scale;
    logic [SGR_COLOR_W-1:0] r_color;
    logic [SGR_SCALE_W-1:0] eff_scale;
    t_reg_index             cfg_reg;

    t_push push;
    t_pop  pop;
    logic  push_ready, pop_ready;

    assign i_cfg.ready = 1'b1;
    assign cfg_reg     = t_reg_index'(i_cfg.index);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= SGR_SCALE_W'(1);
            r_color <= SGR_COLOR_W'(1);
        end else if (i_cfg.valid) begin
            case (cfg_reg)
                REG_SCALE: r_scale <= i_cfg.data[SGR_SCALE_W-1:0];
                REG_COLOR: r_color <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    // zero counts as one, large values clamp
    always_comb begin
        eff_scale = r_scale;
        if (r_scale == '0) begin
            eff_scale = SGR_SCALE_W'(1);
        end else if (r_scale > SGR_SCALE_W'(SGR_MAX_SCALE)) begin
            eff_scale = SGR_SCALE_W'(SGR_MAX_SCALE);
        end
    end

    sgr_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_scale      (eff_scale),
        .o_push       (push),
        .i_push_ready (push_ready)
    );

    sgr_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_push_ready (push_ready),
        .o_pop        (pop),
        .i_pop_ready  (pop_ready)
    );

    sgr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop       (pop),
        .o_pop_ready (pop_ready),
        .i_scale     (eff_scale),
        .i_color     (r_color),
        .o_out       (o_out)
    );

endmodule
